@@ rtl/mfcc_pkg.sv @@
// shared types, constants and the crc-8 byte update for the measurement frame checker
// no dependencies
package mfcc_pkg;

  localparam int FRAME_BYTES_DEF = 18;
  localparam int WORD_COUNT      = 6;
  localparam int WORD_W          = 16;
  localparam int BAD_W           = 3;
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  typedef logic [1:0] phase_t;
  localparam phase_t PH_HIGH = 2'd0;
  localparam phase_t PH_LOW  = 2'd1;
  localparam phase_t PH_CRC  = 2'd2;

  typedef struct packed {
    logic [31:0]      co2_bits;
    logic [31:0]      temperature_bits;
    logic [31:0]      humidity_bits;
    logic             crc_ok;
    logic [BAD_W-1:0] first_bad_group;
  } result_t;

  // msb-first crc-8, no final xor
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/mfcc_frame_core.sv @@
// frame position tracking, per-group crc check and data word capture
// depends on mfcc_pkg
module mfcc_frame_core import mfcc_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_valid,
  input  logic       advance,
  input  logic [7:0] rx_byte,
  input  logic       frame_start,
  output logic       will_result,
  output result_t    result
);

  localparam int POS_W    = $clog2(FRAME_BYTES + 1);
  localparam int GROUPS   = (FRAME_BYTES - 1) / 3 + 1;
  localparam int GROUP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  logic [POS_W-1:0]   pos_r, pos_nxt;
  phase_t             phase_r, phase_nxt;
  logic [GROUP_W-1:0] group_r, group_nxt;
  logic [7:0]         crc_r, crc_nxt;
  logic               err_r, err_nxt;
  logic [BAD_W-1:0]   bad_r, bad_nxt;
  logic [WORD_W-1:0]  words_r [WORD_COUNT];
  logic [WORD_W-1:0]  words_nxt [WORD_COUNT];

  logic [POS_W-1:0]   pos_e, pos_inc;
  phase_t             phase_e;
  logic [GROUP_W-1:0] group_e;
  logic               err_e;
  logic [BAD_W-1:0]   bad_e, bad_sat;
  logic               active;

  // frame_start restarts everything at byte 0
  assign pos_e   = frame_start ? '0 : pos_r;
  assign phase_e = frame_start ? PH_HIGH : phase_r;
  assign group_e = frame_start ? '0 : group_r;
  assign err_e   = frame_start ? 1'b0 : err_r;
  assign bad_e   = frame_start ? '0 : bad_r;
  assign active  = pos_e != POS_W'(FRAME_BYTES);
  assign pos_inc = pos_e + POS_W'(1);
  assign bad_sat = (32'(group_e) > 32'd7) ? BAD_W'(7) : BAD_W'(group_e);

  assign will_result = item_valid && active && (pos_inc == POS_W'(FRAME_BYTES));

  always_comb begin
    pos_nxt   = pos_e;
    phase_nxt = phase_e;
    group_nxt = group_e;
    crc_nxt   = crc_r;
    err_nxt   = err_e;
    bad_nxt   = bad_e;
    for (int i = 0; i < WORD_COUNT; i++) begin
      words_nxt[i] = words_r[i];
    end
    if (active) begin
      pos_nxt = pos_inc;
      case (phase_e)
        PH_HIGH: begin
          crc_nxt   = crc8_byte(CRC_INIT, rx_byte);
          phase_nxt = PH_LOW;
          for (int i = 0; i < WORD_COUNT; i++) begin
            if (32'(group_e) == i) words_nxt[i][15:8] = rx_byte;
          end
        end
        PH_LOW: begin
          crc_nxt   = crc8_byte(crc_r, rx_byte);
          phase_nxt = PH_CRC;
          for (int i = 0; i < WORD_COUNT; i++) begin
            if (32'(group_e) == i) words_nxt[i][7:0] = rx_byte;
          end
        end
        default: begin
          if (rx_byte != crc_r && !err_e) begin
            err_nxt = 1'b1;
            bad_nxt = bad_sat;
          end
          crc_nxt   = CRC_INIT;
          phase_nxt = PH_HIGH;
          group_nxt = group_e + GROUP_W'(1);
        end
      endcase
    end
  end

  always_comb begin
    result.co2_bits         = {words_nxt[0], words_nxt[1]};
    result.temperature_bits = {words_nxt[2], words_nxt[3]};
    result.humidity_bits    = {words_nxt[4], words_nxt[5]};
    result.crc_ok           = !err_nxt;
    result.first_bad_group  = err_nxt ? bad_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_W'(FRAME_BYTES);
      phase_r <= PH_HIGH;
      group_r <= '0;
      crc_r   <= CRC_INIT;
      err_r   <= 1'b0;
      bad_r   <= '0;
    end else if (advance) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      group_r <= group_nxt;
      crc_r   <= crc_nxt;
      err_r   <= err_nxt;
      bad_r   <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < WORD_COUNT; i++) begin
        words_r[i] <= words_nxt[i];
      end
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(FRAME_BYTES))
    else $error("byte position beyond frame length");
  a_phase_valid: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd3)
    else $error("illegal group phase");
  a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && frame_start) |=> (!err_r && pos_r == POS_W'(1) && phase_r == PH_LOW))
    else $error("frame restart did not clear state");
  a_result_ok_code: assert property (@(posedge clk) disable iff (!rst_n)
    (will_result && result.crc_ok) |-> (result.first_bad_group == '0))
    else $error("bad group reported on a clean frame");

endmodule

@@ rtl/mfcc_result_reg.sv @@
// output register holding one finished frame result until the receiver takes it
// depends on mfcc_pkg
module mfcc_result_reg import mfcc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t result,
  input  logic    out_stall,
  output logic    out_valid,
  output result_t out_data
);

  logic    valid_r, valid_nxt;
  result_t data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ rtl/measurement_frame_crc_checker.sv @@
// measurement frame crc checker: input register, frame core and result register
// depends on mfcc_pkg, mfcc_frame_core, mfcc_result_reg
//
// usage:
//   bytes of an 18-byte sensor measurement response arrive on in_rx_byte with
//   in_valid; in_frame_start marks byte 0 and restarts any frame in progress.
//   bytes seen while idle (after reset or after a complete frame) are dropped.
//   on the last byte one result appears on the out_ channel: three 32-bit raw
//   float patterns, crc_ok, and the index of the first group whose crc failed.
// throughput: one byte per cycle while not stalled; each byte's crc update is
//   a shallow xor network between the input and state/result registers.
// sequence: an accepted byte waits in the input register until it advances; the
//   result is loaded into the result register as the frame's last byte advances.
// stall: the result register and the input register each hold one item, so a
//   byte is still taken while a result waits; only when a result waits, the
//   input register holds a frame-ending byte and out_stall is high does
//   in_stall rise.
// reset: rst_n synchronous, active low; the block comes up idle and waits for
//   a frame_start byte.
module measurement_frame_crc_checker import mfcc_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_co2_bits,
  output logic [31:0] out_temperature_bits,
  output logic [31:0] out_humidity_bits,
  output logic        out_crc_ok,
  output logic [2:0]  out_first_bad_group
);

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] byte_r;
  logic       start_r;
  logic       accept, advance, will_result, load;
  result_t    core_result, out_data;

  assign load     = advance && will_result;
  // a byte that ends a frame needs room in the result register
  assign advance  = in_valid_r && (!will_result || !out_valid || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r  <= in_rx_byte;
      start_r <= in_frame_start;
    end
  end

  mfcc_frame_core #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (in_valid_r),
    .advance     (advance),
    .rx_byte     (byte_r),
    .frame_start (start_r),
    .will_result (will_result),
    .result      (core_result)
  );

  mfcc_result_reg u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .result    (core_result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign out_co2_bits         = out_data.co2_bits;
  assign out_temperature_bits = out_data.temperature_bits;
  assign out_humidity_bits    = out_data.humidity_bits;
  assign out_crc_ok           = out_data.crc_ok;
  assign out_first_bad_group  = out_data.first_bad_group;

endmodule
